// ----- hdl/pfla_pkg.sv -----
// Shared constants, codes, command/status types and helpers for the page allocator.
`default_nettype none

package pfla_pkg;

    // Sizing
    localparam int CPU_COUNT  = 8;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    // Fixed field widths
    localparam int KIND_W   = 1;
    localparam int CPU_W    = 3;
    localparam int ADDR_W   = 40;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 28;
    localparam int CFG_IDX_W = 1;

    // Packed stream widths (whole bytes)
    localparam int S_TDATA_RAW = CPU_W + ADDR_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ADDR_W + 7) / 8) * 8;

    // Derived widths
    localparam int CPU_IDX_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int SLOT_W    = $clog2(MAX_PAGES);
    localparam int LINK_W    = $clog2(MAX_PAGES + 1);
    localparam int PFN_W     = ADDR_W - PAGE_SHIFT;
    localparam int CMP_W     = (PFN_W > CFG_W) ? PFN_W : CFG_W;
    localparam int GRANT_W   = ADDR_W + CFG_W;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] LOWEST_PAGE_RST = CFG_W'(524288);
    localparam logic [CFG_W-1:0] TOP_PAGE_RST    = CFG_W'(557056);
    localparam logic [LINK_W-1:0] EMPTY_MARK     = LINK_W'(MAX_PAGES);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST_PAGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PAGE    = CFG_IDX_W'(1);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FREED     = 2'd0,
        ST_ALLOCATED = 2'd1,
        ST_NO_MEMORY = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    // Controller -> datapath
    typedef struct packed {
        logic    load_item;    // capture the accepted word
        logic    read_link;    // read next link of the chosen list's top page
        logic    commit_free;  // push the page
        logic    commit_pop;   // pop the page, head takes the read link
        logic    load_result;  // fill the output register
        status_t code;
    } pfla_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic bad_free;
        logic all_empty;
    } pfla_stat_t;

    // cpu index taken modulo CPU_COUNT
    function automatic logic [CPU_IDX_W-1:0] cpu_wrap(input logic [CPU_W-1:0] c);
        int v;
        v = int'(c);
        for (int i = 0; i < (1 << CPU_W); i++) begin
            if (v >= CPU_COUNT) begin
                v = v - CPU_COUNT;
            end
        end
        return CPU_IDX_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/pfla_ctrl.sv -----
// Request sequencer: handshakes, state and command generation.
`default_nettype none

module pfla_ctrl
    import pfla_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire pfla_stat_t stat,
    output pfla_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_POP
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // output register can take a word this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.code          = ST_FREED;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.is_alloc && !stat.all_empty) begin
                    cmd.read_link = 1'b1;
                    state_next    = S_POP;
                end else if (out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                    if (stat.is_alloc) begin
                        cmd.code = ST_NO_MEMORY;
                    end else if (stat.bad_free) begin
                        cmd.code = ST_BAD_FREE;
                    end else begin
                        cmd.code        = ST_FREED;
                        cmd.commit_free = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    cmd.commit_pop  = 1'b1;
                    cmd.load_result = 1'b1;
                    cmd.code        = ST_ALLOCATED;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.load_result) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- hdl/pfla_dp.sv -----
// Datapath: list heads, link RAM, address checks, config and result registers.
`default_nettype none

module pfla_dp
    import pfla_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [KIND_W-1:0]    s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic      [STATUS_W-1:0]  m_tuser,
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire pfla_cmd_t            cmd,
    output pfla_stat_t                stat
);

    // captured request
    logic [KIND_W-1:0]    kind_reg;
    logic [CPU_IDX_W-1:0] cpu_reg;
    logic [ADDR_W-1:0]    addr_reg;

    // configuration
    logic [CFG_W-1:0] lowest_reg;
    logic [CFG_W-1:0] top_reg;

    // list heads, EMPTY_MARK when a list is empty
    logic [LINK_W-1:0] head_reg [CPU_COUNT];

    // chosen list and its top slot, held across the link read
    logic [CPU_IDX_W-1:0] tgt_reg;
    logic [SLOT_W-1:0]    tgt_slot_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   granted_reg;

    logic [CPU_COUNT-1:0] nonempty;
    logic [CPU_IDX_W-1:0] first_src;
    logic [CPU_IDX_W-1:0] alloc_src;
    logic [CPU_IDX_W-1:0] target;
    logic [LINK_W-1:0]    target_head;

    logic [CMP_W-1:0]  pfn;
    logic [CMP_W-1:0]  low_x;
    logic [CMP_W-1:0]  top_x;
    logic [CMP_W-1:0]  diff;
    logic              misaligned;
    logic [SLOT_W-1:0] free_slot;

    logic [CFG_W:0]       gsum;
    logic [GRANT_W-1:0]   gshift;
    logic [LINK_W-1:0]    link_rdata;

    // list state
    always_comb begin
        first_src = '0;
        for (int i = CPU_COUNT - 1; i >= 0; i--) begin
            nonempty[i] = (head_reg[i] < EMPTY_MARK);
            if (head_reg[i] < EMPTY_MARK) begin
                first_src = CPU_IDX_W'(i);
            end
        end
    end

    assign alloc_src   = nonempty[cpu_reg] ? cpu_reg : first_src;
    assign target      = (kind_reg == KIND_ALLOC) ? alloc_src : cpu_reg;
    assign target_head = head_reg[target];

    // free address checks
    assign pfn        = CMP_W'(addr_reg[ADDR_W-1:PAGE_SHIFT]);
    assign low_x      = CMP_W'(lowest_reg);
    assign top_x      = CMP_W'(top_reg);
    assign diff       = pfn - low_x;
    assign misaligned = |addr_reg[PAGE_SHIFT-1:0];
    assign free_slot  = diff[SLOT_W-1:0];

    assign stat.is_alloc  = (kind_reg == KIND_ALLOC);
    assign stat.all_empty = !(|nonempty);
    assign stat.bad_free  = misaligned || (pfn < low_x) || (pfn >= top_x)
                            || (diff >= CMP_W'(MAX_PAGES));

    // granted byte address
    assign gsum   = (CFG_W+1)'(lowest_reg) + (CFG_W+1)'(tgt_slot_reg);
    assign gshift = GRANT_W'(gsum) << PAGE_SHIFT;

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (cmd.commit_free),
        .waddr (free_slot),
        .wdata (target_head),
        .re    (cmd.read_link),
        .raddr (target_head[SLOT_W-1:0]),
        .rdata (link_rdata)
    );

    // control state: heads and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CPU_COUNT; i++) begin
                head_reg[i] <= EMPTY_MARK;
            end
            lowest_reg <= LOWEST_PAGE_RST;
            top_reg    <= TOP_PAGE_RST;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_LOWEST_PAGE: lowest_reg <= cfg_data;
                    REG_TOP_PAGE:    top_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit_free) begin
                head_reg[cpu_reg] <= LINK_W'(free_slot);
            end
            if (cmd.commit_pop) begin
                head_reg[tgt_reg] <= link_rdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= s_tuser;
            cpu_reg  <= cpu_wrap(s_tdata[CPU_W-1:0]);
            addr_reg <= s_tdata[CPU_W +: ADDR_W];
        end
        if (cmd.read_link) begin
            tgt_reg      <= target;
            tgt_slot_reg <= target_head[SLOT_W-1:0];
        end
        if (cmd.load_result) begin
            status_reg  <= cmd.code;
            granted_reg <= cmd.commit_pop ? gshift[ADDR_W-1:0] : '0;
        end
    end

    assign m_tuser = status_reg;
    assign m_tdata = M_TDATA_W'(granted_reg);

endmodule

`default_nettype wire

// ----- hdl/per_cpu_page_free_list_allocator.sv -----
// Top level of the per-CPU page free-list allocator with cross-CPU stealing.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ------------------------------------------
//  s_       in   s_tvalid / s_tready    tuser: kind; tdata: cpu, page_address
//  m_       out  m_tvalid / m_tready    tuser: status; tdata: granted_address
//  cfg_     in   cfg_valid / cfg_ready  cfg_index (0 lowest_page, 1 top_page), cfg_data
//
// Sequence: a free or a failed request passes the accept and decide states; its
//   result loads when decide completes with the output register free. An allocate adds
//   a pop state: decide issues the registered link RAM read, pop loads the result.
// Requests are taken one at a time: a new one is accepted only once the last result is loaded.
// Reset clears the list heads to empty and loads the config defaults; the
//   link RAM is not cleared, only pushed pages are ever read back.
// A held result in the output register stalls completion, not acceptance.
// cfg_ready is always high.
`default_nettype none

module per_cpu_page_free_list_allocator
    import pfla_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [KIND_W-1:0]    s_tuser,   // [0] kind
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [2:0] cpu, [42:3] page_address, rest zero
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic      [M_TDATA_W-1:0] m_tdata,   // [39:0] granted_address
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    pfla_cmd_t  cmd;
    pfla_stat_t stat;

    assign cfg_ready = 1'b1;

    pfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfla_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ----- tb/per_cpu_page_free_list_allocator_tb.sv -----
// Self-checking testbench for the per-CPU page free-list allocator, with its own allocator model.
module per_cpu_page_free_list_allocator_tb
    import pfla_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // ---------------------------------------------------------------- constants
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 75;
    localparam int SETTLE_CYCLES  = 4;     // lets an allocate drain through decide and pop
    localparam int WATCHDOG_LIMIT = 400;   // well above the longest idle burst on either side

    // Address window per phase: defaults, tiny window at zero, window against the
    // top of the frame space, inverted window, full frame space, short tail window.
    localparam int PHASE_LO [PHASES] = '{524288, 0, 'h0FFFFFD7, 'h0FFFFFFF, 0, 'h12345};
    localparam int PHASE_HI [PHASES] = '{557056, 16, 'h0FFFFFFF, 0, 'h0FFFFFFF, 'h12385};
    // Percentage of allocate words in each phase; high values drain the lists
    localparam int PHASE_ALLOC [PHASES] = '{40, 50, 45, 70, 35, 55};

    // ---------------------------------------------------------------- types
    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   granted;
    } grant_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [CPU_W-1:0]    cpu;
        logic [ADDR_W-1:0]   addr;
        bit                  fixed;     // expected value typed in below
        grant_t              want;
    } probe_t;

    // ---------------------------------------------------------------- DUT ports
    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [KIND_W-1:0]      s_tuser;    // [0] kind
    logic [S_TDATA_W-1:0]   s_tdata;    // [2:0] cpu, [42:3] page_address, rest zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [STATUS_W-1:0]    m_tuser;    // [1:0] status
    logic [M_TDATA_W-1:0]   m_tdata;    // [39:0] granted_address
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    per_cpu_page_free_list_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------- allocator model state
    logic [LINK_W-1:0]  head_slot [CPU_COUNT];   // top slot of each CPU's list
    logic [LINK_W-1:0]  link_slot [MAX_PAGES];   // next slot below each pushed page
    bit                 on_list   [MAX_PAGES];   // slot currently sits in some list
    logic [CFG_W-1:0]   lowest_cfg;
    logic [CFG_W-1:0]   top_cfg;

    grant_t             pending_results [$];     // expected result words, oldest first
    probe_t             probes [24];
    int                 fault_count  = 0;
    int                 quiet_cycles = 0;
    bit                 idle_on      = 1'b1;     // random idling on both sides

    // ---------------------------------------------------------------- model
    // Applies one request word to the model lists and returns the result word.
    function automatic grant_t predict_grant(input logic [KIND_W-1:0] kind,
                                             input logic [CPU_W-1:0] cpu_in,
                                             input logic [ADDR_W-1:0] addr);
        grant_t           r;
        int               c;
        int               src;
        longint unsigned  pfn;
        longint unsigned  slot;
        longint unsigned  frame;
        r.status  = ST_FREED;
        r.granted = '0;
        c = int'(cpu_in) % CPU_COUNT;
        if (kind == KIND_FREE) begin
            pfn = addr >> PAGE_SHIFT;
            // misaligned, outside [lowest, top), or beyond the link table
            if (addr[PAGE_SHIFT-1:0] != '0 || pfn < lowest_cfg || pfn >= top_cfg ||
                pfn - lowest_cfg >= MAX_PAGES) begin
                r.status = ST_BAD_FREE;
            end else begin
                slot            = pfn - lowest_cfg;
                link_slot[slot] = head_slot[c];
                head_slot[c]    = LINK_W'(slot);
                on_list[slot]   = 1'b1;
            end
        end else begin
            src = CPU_COUNT;
            if (head_slot[c] < EMPTY_MARK) begin
                src = c;
            end else begin
                // steal: first non-empty list in ascending CPU order
                for (int j = 0; j < CPU_COUNT; j++) begin
                    if (j != c && src == CPU_COUNT && head_slot[j] < EMPTY_MARK) begin
                        src = j;
                    end
                end
            end
            if (src == CPU_COUNT) begin
                r.status = ST_NO_MEMORY;
            end else begin
                slot           = head_slot[src];
                head_slot[src] = link_slot[slot];
                on_list[slot]  = 1'b0;
                // frame is rebuilt from the current window base, wrapped to 40 bits
                frame          = lowest_cfg + slot;
                r.status       = ST_ALLOCATED;
                r.granted      = ADDR_W'(frame << PAGE_SHIFT);
            end
        end
        return r;
    endfunction

    // Number of slots a legal free can reach under the current window.
    function automatic longint unsigned free_span();
        longint unsigned span;
        span = 0;
        if (top_cfg > lowest_cfg) begin
            span = top_cfg - lowest_cfg;
        end
        if (span > MAX_PAGES) begin
            span = MAX_PAGES;
        end
        return span;
    endfunction

    function automatic logic [ADDR_W-1:0] junk_address();
        longint unsigned w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    // Free addresses that the block has to reject.
    function automatic logic [ADDR_W-1:0] bad_address();
        longint unsigned   frame;
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 4))
            0: begin
                a = junk_address();                      // random, nearly always bad
            end
            1: begin
                frame = lowest_cfg - 1;                  // one frame below the window
                a = ADDR_W'(frame << PAGE_SHIFT);
            end
            2: begin
                frame = top_cfg;                         // first frame past the window
                a = ADDR_W'(frame << PAGE_SHIFT);
            end
            3: begin
                frame = lowest_cfg + MAX_PAGES;          // past the link table
                a = ADDR_W'(frame << PAGE_SHIFT);
            end
            default: begin
                frame = lowest_cfg + $urandom_range(0, 15);
                a = ADDR_W'(frame << PAGE_SHIFT);
                a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
            end
        endcase
        return a;
    endfunction

    // ---------------------------------------------------------------- drivers
    // Drives one request word at the falling edge and queues its expected result
    // once the block takes it.
    task automatic push_word(input logic [KIND_W-1:0] kind, input logic [CPU_W-1:0] cpu_in,
                             input logic [ADDR_W-1:0] addr, input bit fixed,
                             input grant_t fixed_want);
        grant_t predicted;
        int     gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({addr, cpu_in});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_grant(kind, cpu_in, addr);
        pending_results.push_back(fixed ? fixed_want : predicted);
    endtask

    // One random word: mostly legal frees of pages not held in any list and
    // allocations; the rest are rejected frees.
    task automatic random_word(input int alloc_pct);
        logic [CPU_W-1:0]  cpu_r;
        logic [ADDR_W-1:0] addr;
        longint unsigned   span;
        longint unsigned   slot;
        longint unsigned   frame;
        bit                found;
        int                roll;
        cpu_r = CPU_W'($urandom_range(0, (1 << CPU_W) - 1));
        addr  = junk_address();                  // allocate ignores the address
        span  = free_span();
        roll  = $urandom_range(0, 99);
        found = 1'b0;
        slot  = 0;
        if (roll >= alloc_pct + 10 && span != 0) begin
            // a page already on a list would make a double free; pick another
            for (int t = 0; t < 8 && !found; t++) begin
                slot  = $urandom_range(0, int'(span - 1));
                found = !on_list[slot];
            end
        end
        if (found) begin
            frame = lowest_cfg + slot;
            push_word(KIND_FREE, cpu_r, ADDR_W'(frame << PAGE_SHIFT), 1'b0, '0);
        end else if (roll >= alloc_pct && roll < alloc_pct + 10 || span == 0 && roll >= alloc_pct) begin
            push_word(KIND_FREE, cpu_r, bad_address(), 1'b0, '0);
        end else begin
            push_word(KIND_ALLOC, cpu_r, addr, 1'b0, '0);
        end
    endtask

    // Rewrites the address window once the block has nothing in flight.
    task automatic set_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOWEST_PAGE;
        cfg_data  <= lo;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        lowest_cfg = lo;
        @(negedge aclk);
        cfg_index <= REG_TOP_PAGE;
        cfg_data  <= hi;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        top_cfg = hi;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- result side backpressure
    // Random stall bursts; always ready once idling is switched off.
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!idle_on) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall    = stall - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall    = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- result checker
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d, granted_address %h",
                       m_tuser, m_tdata);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fault_count++;
                end
                if (m_tdata !== M_TDATA_W'(want.granted)) begin
                    $error("granted_address: expected %h, actual %h", want.granted, m_tdata);
                    fault_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    // Any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = KIND_FREE;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOWEST_PAGE;
        cfg_data  = '0;
        for (int i = 0; i < CPU_COUNT; i++) begin
            head_slot[i] = EMPTY_MARK;
        end
        lowest_cfg = LOWEST_PAGE_RST;
        top_cfg    = TOP_PAGE_RST;

        // Directed words at the reset window: frames 0x80000 .. 0x87fff.
        // Fixed rows are read straight off the rules; the rest go through the model.
        probes = '{
            // empty store
            '{KIND_ALLOC, 3'd0, 40'h00_0000_0000, 1'b1, '{ST_NO_MEMORY, 40'h0}},
            '{KIND_ALLOC, 3'd7, 40'hFF_FFFF_FFFF, 1'b1, '{ST_NO_MEMORY, 40'h0}},
            // rejected frees: misaligned, below, at top, zero, all ones, top frame
            '{KIND_FREE,  3'd1, 40'h00_8000_0001, 1'b1, '{ST_BAD_FREE,  40'h0}},
            '{KIND_FREE,  3'd1, 40'h00_7FFF_F000, 1'b1, '{ST_BAD_FREE,  40'h0}},
            '{KIND_FREE,  3'd1, 40'h00_8800_0000, 1'b1, '{ST_BAD_FREE,  40'h0}},
            '{KIND_FREE,  3'd0, 40'h00_0000_0000, 1'b1, '{ST_BAD_FREE,  40'h0}},
            '{KIND_FREE,  3'd7, 40'hFF_FFFF_FFFF, 1'b1, '{ST_BAD_FREE,  40'h0}},
            '{KIND_FREE,  3'd7, 40'hFF_FFFF_F000, 1'b1, '{ST_BAD_FREE,  40'h0}},
            // first and last managed page
            '{KIND_FREE,  3'd0, 40'h00_8000_0000, 1'b1, '{ST_FREED,     40'h0}},
            '{KIND_FREE,  3'd7, 40'h00_87FF_F000, 1'b1, '{ST_FREED,     40'h0}},
            '{KIND_ALLOC, 3'd7, 40'h00_0000_0000, 1'b1, '{ST_ALLOCATED, 40'h00_87FF_F000}},
            // own list empty: steal from CPU 0
            '{KIND_ALLOC, 3'd5, 40'h00_0000_0000, 1'b1, '{ST_ALLOCATED, 40'h00_8000_0000}},
            '{KIND_ALLOC, 3'd5, 40'h00_0000_0000, 1'b1, '{ST_NO_MEMORY, 40'h0}},
            // same page freed onto two lists
            '{KIND_FREE,  3'd2, 40'h00_8000_5000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_FREE,  3'd4, 40'h00_8000_5000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_FREE,  3'd6, 40'h00_8000_1000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_FREE,  3'd6, 40'h00_8000_2000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_ALLOC, 3'd4, 40'h00_0000_0000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_ALLOC, 3'd2, 40'hAA_AAAA_AAAA, 1'b0, '{ST_FREED, 40'h0}},
            // steal skips the empty lower lists
            '{KIND_ALLOC, 3'd1, 40'h55_5555_5555, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_ALLOC, 3'd6, 40'h00_0000_0000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_ALLOC, 3'd3, 40'h00_0000_0000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_FREE,  3'd3, 40'h00_8000_3000, 1'b0, '{ST_FREED, 40'h0}},
            '{KIND_ALLOC, 3'd0, 40'h00_0000_0000, 1'b0, '{ST_FREED, 40'h0}}
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) begin
            push_word(probes[i].kind, probes[i].cpu, probes[i].addr, probes[i].fixed,
                      probes[i].want);
        end

        // Random phases; pages held at a window change stay on their lists,
        // so later windows hand them out under the new base.
        for (int p = 0; p < PHASES; p++) begin
            set_window(CFG_W'(PHASE_LO[p]), CFG_W'(PHASE_HI[p]));
            if (p == PHASES - 1) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) random_word(PHASE_ALLOC[p]);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pfla_pkg.sv
hdl/pfla_ram.sv
hdl/pfla_ctrl.sv
hdl/pfla_dp.sv
hdl/per_cpu_page_free_list_allocator.sv
tb/per_cpu_page_free_list_allocator_tb.sv
